/* rtl/phts_pkg.sv */
// Shared types, constants and codes of the per-host traffic stats table.
`default_nettype none
package phts_pkg;

    localparam int ENTRIES_DEF = 256;
    localparam int PADDR_W = 4;
    localparam logic [15:0] FRAME_HDR_BYTES = 16'd14;

    // register indexes on the configuration port
    localparam logic [1:0] REG_ENABLE = 2'd0;
    localparam logic [1:0] REG_SUBNET_ADDR = 2'd1;
    localparam logic [1:0] REG_SUBNET_MASK = 2'd2;
    localparam logic [1:0] REG_OFFLINE_TIMEOUT = 2'd3;

    // request codes
    localparam logic [2:0] REQ_PACKET = 3'd0;
    localparam logic [2:0] REQ_TICK = 3'd1;
    localparam logic [2:0] REQ_SNAPSHOT = 3'd2;
    localparam logic [2:0] REQ_READ = 3'd3;
    localparam logic [2:0] REQ_FLUSH = 3'd4;

    typedef enum logic [2:0] {
        ST_TX = 3'd0,
        ST_RX = 3'd1,
        ST_NOTLOCAL = 3'd2,
        ST_DISABLED = 3'd3,
        ST_BADHDR = 3'd4,
        ST_ZERO = 3'd5,
        ST_DONE = 3'd6,
        ST_READ = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CHK,
        S_ALLOC,
        S_RES
    } state_t;

    typedef struct packed {
        logic        enable;
        logic [31:0] subnet_addr;
        logic [31:0] subnet_mask;
        logic [15:0] offline_timeout;
    } cfg_t;

    typedef struct packed {
        logic [31:0] txp;
        logic [31:0] txb;
        logic [31:0] rxp;
        logic [31:0] rxb;
    } counts_t;

    typedef struct packed {
        logic [31:0] addr;
        logic [47:0] mac;
        counts_t     live;
        counts_t     snap_now;
        counts_t     snap_before;
        logic [31:0] last_seen;
        logic        idle;
    } row_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  slot;
        logic        entry_valid;
        logic        new_entry;
        logic [31:0] host_ip;
        logic [47:0] host_mac;
        logic        offline;
        counts_t     counts;
    } result_t;

endpackage
`default_nettype wire

/* rtl/phts_if.sv */
// Valid/ready channel interfaces for request items and result items.
`default_nettype none
interface phts_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [47:0] src_mac;
    logic [47:0] dst_mac;
    logic [15:0] ip_total_len;
    logic        mac_header_ok;
    logic [7:0]  slot_index;
    logic        read_view;

    modport source (output valid, req_type, src_ip, dst_ip, src_mac, dst_mac,
                    ip_total_len, mac_header_ok, slot_index, read_view, input ready);
    modport sink (input valid, req_type, src_ip, dst_ip, src_mac, dst_mac,
                  ip_total_len, mac_header_ok, slot_index, read_view, output ready);
endinterface

interface phts_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  slot;
    logic        entry_valid;
    logic        new_entry;
    logic [31:0] host_ip;
    logic [47:0] host_mac;
    logic        offline;
    logic [31:0] tx_packets;
    logic [31:0] tx_bytes;
    logic [31:0] rx_packets;
    logic [31:0] rx_bytes;

    modport source (output valid, status, slot, entry_valid, new_entry, host_ip, host_mac,
                    offline, tx_packets, tx_bytes, rx_packets, rx_bytes, input ready);
    modport sink (input valid, status, slot, entry_valid, new_entry, host_ip, host_mac,
                  offline, tx_packets, tx_bytes, rx_packets, rx_bytes, output ready);
endinterface
`default_nettype wire

/* rtl/per_host_traffic_stats_table_unit.sv */
// Top level of the per-host traffic stats table.
// Requests arrive on in_ch (valid/ready), one result per request leaves on out_ch.
// Configuration is written through the APB-style port; the user must write it only
// while the block is idle (the block does not enforce this). One request at a time:
// ready is high only while the sequencer waits. Work per request: a packet hit reads
// rows in order until the hit, then writes the updated row back; a packet miss
// searches every row, then allocates one; tick and snapshot read and write back each
// valid row; a read of a valid slot reads that row; rejected packets, reads of empty
// slots, flush and others go straight to the result.
// Results sit in an output register; the next request is accepted while a result
// waits, and the sequencer holds its next result until the receiver takes the last.
// Reset empties the table (fill count zero), clears the clock and the output, and
// loads the register defaults. Row memory needs no clearing pass.
`default_nettype none
module per_host_traffic_stats_table_unit #(
    parameter int ENTRIES = phts_pkg::ENTRIES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    phts_in_if.sink                      in_ch,
    phts_out_if.source                   out_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [phts_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import phts_pkg::*;

    localparam int IW = $clog2(ENTRIES);

    cfg_t          cfg;
    logic [IW-1:0] ram_addr;
    logic          ram_we;
    row_t          ram_wdata;
    row_t          ram_rdata;

    phts_cfg u_cfg (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
    );

    phts_ram #(.DEPTH(ENTRIES), .WIDTH($bits(row_t))) u_ram (
        .clk(clk), .addr(ram_addr), .we(ram_we), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    phts_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .cfg(cfg), .in_ch(in_ch), .out_ch(out_ch),
        .ram_addr(ram_addr), .ram_we(ram_we), .ram_wdata(ram_wdata), .ram_rdata(ram_rdata)
    );
endmodule
`default_nettype wire

/* rtl/phts_ram.sv */
// Single-port synchronous RAM with a registered read port.
`default_nettype none
module phts_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic [AW-1:0]    addr,
    input  logic             we,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

/* rtl/phts_cfg.sv */
// APB-style configuration registers.
`default_nettype none
module phts_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [phts_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output phts_pkg::cfg_t               cfg
);
    import phts_pkg::*;

    cfg_t cfg_reg;
    logic wr;

    assign wr = psel && penable && pwrite;
    assign pready = 1'b1;

    // write registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable <= 1'b1;
            cfg_reg.subnet_addr <= 32'hC0A8_0001;
            cfg_reg.subnet_mask <= 32'hFFFF_FF00;
            cfg_reg.offline_timeout <= 16'd60;
        end
        else if (wr)
        begin
            unique case (paddr[3:2])
                REG_ENABLE: cfg_reg.enable <= pwdata[0];
                REG_SUBNET_ADDR: cfg_reg.subnet_addr <= pwdata;
                REG_SUBNET_MASK: cfg_reg.subnet_mask <= pwdata;
                REG_OFFLINE_TIMEOUT: cfg_reg.offline_timeout <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        unique case (paddr[3:2])
            REG_ENABLE: prdata = {31'd0, cfg_reg.enable};
            REG_SUBNET_ADDR: prdata = cfg_reg.subnet_addr;
            REG_SUBNET_MASK: prdata = cfg_reg.subnet_mask;
            REG_OFFLINE_TIMEOUT: prdata = {16'd0, cfg_reg.offline_timeout};
            default: prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;
endmodule
`default_nettype wire

/* rtl/phts_ctrl.sv */
// Sequencer: classifies items, searches and updates table rows, holds the result.
`default_nettype none
module phts_ctrl #(
    parameter int ENTRIES = phts_pkg::ENTRIES_DEF,
    localparam int IW = $clog2(ENTRIES)
) (
    input  logic           clk,
    input  logic           rst_n,
    input  phts_pkg::cfg_t cfg,
    phts_in_if.sink        in_ch,
    phts_out_if.source     out_ch,
    output logic [IW-1:0]  ram_addr,
    output logic           ram_we,
    output phts_pkg::row_t ram_wdata,
    input  phts_pkg::row_t ram_rdata
);
    import phts_pkg::*;

    localparam logic [IW:0] FULL = (IW+1)'(ENTRIES);
    localparam logic [IW-1:0] LAST_SLOT = IW'(ENTRIES - 1);

    state_t      state_reg, state_next;
    logic [2:0]  op_reg, op_next;
    logic        tx_reg, tx_next;
    logic [31:0] addr_reg, addr_next;
    logic [47:0] mac_reg, mac_next;
    logic [31:0] len_reg, len_next;
    logic        view_reg, view_next;
    logic [IW:0] idx_reg, idx_next;
    logic [IW:0] fill_reg, fill_next;
    logic [IW-1:0] victim_reg, victim_next;
    logic [31:0] now_reg, now_next;
    result_t     res_reg, res_next;
    result_t     out_reg, out_next;
    logic        out_valid_reg, out_valid_next;

    logic        acc;
    logic        hit;
    logic        last;
    logic        full;
    logic [IW-1:0] alloc_slot;
    logic [IW+8:0] sidx_w;
    logic        read_ok;
    status_t     cls_status;
    logic        cls_tx;
    logic [31:0] cls_addr;
    logic [47:0] cls_mac;
    logic [31:0] net;
    row_t        new_row;

    function automatic logic [7:0] slot8(input logic [IW-1:0] i);
        logic [IW+7:0] w;
        w = {8'd0, i};
        return w[7:0];
    endfunction

    function automatic row_t apply_pkt(input row_t r, input logic tx, input logic [47:0] mac,
                                       input logic [31:0] len, input logic [31:0] now);
        row_t u;
        u = r;
        if (mac != 48'd0)
        begin
            u.mac = mac;
        end
        if (tx)
        begin
            u.live.txp = r.live.txp + 32'd1;
            u.live.txb = r.live.txb + len;
        end
        else
        begin
            u.live.rxp = r.live.rxp + 32'd1;
            u.live.rxb = r.live.rxb + len;
        end
        u.last_seen = now;
        u.idle = 1'b0;
        return u;
    endfunction

    function automatic result_t report(input row_t r, input counts_t c, input logic [7:0] s,
                                       input status_t st, input logic fresh);
        result_t o;
        o = '0;
        o.status = st;
        o.slot = s;
        o.entry_valid = 1'b1;
        o.new_entry = fresh;
        o.host_ip = r.addr;
        o.host_mac = r.mac;
        o.offline = r.idle;
        o.counts = c;
        return o;
    endfunction

    assign in_ch.ready = (state_reg == S_IDLE);
    assign acc = in_ch.valid && in_ch.ready;
    assign hit = (ram_rdata.addr == addr_reg);
    assign last = ((idx_reg + 1'b1) == fill_reg);
    assign full = (fill_reg == FULL);
    assign alloc_slot = full ? victim_reg : fill_reg[IW-1:0];
    assign sidx_w = {{(IW+1){1'b0}}, in_ch.slot_index};
    assign read_ok = (sidx_w < {8'd0, fill_reg});

    // classify a packet against the subnet
    always_comb
    begin
        net = cfg.subnet_addr & cfg.subnet_mask;
        cls_tx = 1'b0;
        cls_addr = in_ch.dst_ip;
        cls_mac = in_ch.dst_mac;
        cls_status = ST_RX;
        priority if (!cfg.enable)
        begin
            cls_status = ST_DISABLED;
        end
        else if (cfg.subnet_addr == 32'd0 && cfg.subnet_mask == 32'd0)
        begin
            cls_status = ST_NOTLOCAL;
        end
        else if ((in_ch.src_ip & cfg.subnet_mask) == net)
        begin
            cls_tx = 1'b1;
            cls_addr = in_ch.src_ip;
            cls_mac = in_ch.src_mac;
            if (!in_ch.mac_header_ok)
            begin
                cls_status = ST_BADHDR;
            end
            else if (in_ch.src_ip == 32'd0)
            begin
                cls_status = ST_ZERO;
            end
            else
            begin
                cls_status = ST_TX;
            end
        end
        else if ((in_ch.dst_ip & cfg.subnet_mask) == net)
        begin
            cls_status = (in_ch.dst_ip == 32'd0) ? ST_ZERO : ST_RX;
        end
        else
        begin
            cls_status = ST_NOTLOCAL;
        end
    end

    // fresh row for an allocated slot
    always_comb
    begin
        new_row = '0;
        new_row.addr = addr_reg;
        new_row.mac = mac_reg;
        new_row.last_seen = now_reg;
        new_row.idle = 1'b1;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    priority case (in_ch.req_type)
                        REQ_PACKET:
                        begin
                            if (cls_status != ST_TX && cls_status != ST_RX)
                                state_next = S_RES;
                            else if (fill_reg == '0)
                                state_next = S_ALLOC;
                            else
                                state_next = S_RD;
                        end
                        REQ_TICK, REQ_SNAPSHOT:
                            state_next = (fill_reg == '0) ? S_RES : S_RD;
                        REQ_READ:
                            state_next = read_ok ? S_RD : S_RES;
                        default:
                            state_next = S_RES;
                    endcase
                end
            end
            S_RD:
                state_next = S_CHK;
            S_CHK:
            begin
                priority if (op_reg == REQ_PACKET && hit)
                    state_next = S_RES;
                else if (op_reg == REQ_PACKET)
                    state_next = last ? S_ALLOC : S_RD;
                else if (op_reg == REQ_READ)
                    state_next = S_RES;
                else
                    state_next = last ? S_RES : S_RD;
            end
            S_ALLOC:
                state_next = S_RES;
            S_RES:
            begin
                if (!out_valid_reg || out_ch.ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and memory access
    always_comb
    begin
        row_t    r;
        counts_t c;
        logic [31:0] d;
        op_next = op_reg;
        tx_next = tx_reg;
        addr_next = addr_reg;
        mac_next = mac_reg;
        len_next = len_reg;
        view_next = view_reg;
        idx_next = idx_reg;
        fill_next = fill_reg;
        victim_next = victim_reg;
        now_next = now_reg;
        res_next = res_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg;
        ram_addr = idx_reg[IW-1:0];
        ram_we = 1'b0;
        ram_wdata = ram_rdata;
        r = ram_rdata;
        c = ram_rdata.live;
        d = 32'd0;

        // drop the output once taken
        if (out_valid_reg && out_ch.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    op_next = in_ch.req_type;
                    tx_next = cls_tx;
                    addr_next = cls_addr;
                    mac_next = cls_mac;
                    len_next = {16'd0, in_ch.ip_total_len} + {16'd0, FRAME_HDR_BYTES};
                    view_next = in_ch.read_view;
                    idx_next = '0;
                    res_next = '0;
                    res_next.status = ST_DONE;
                    priority case (in_ch.req_type)
                        REQ_PACKET:
                            res_next.status = cls_status;
                        REQ_TICK:
                        begin
                            if (fill_reg == '0)
                                now_next = now_reg + 32'd1;
                        end
                        REQ_READ:
                        begin
                            res_next.status = ST_READ;
                            res_next.slot = in_ch.slot_index;
                            idx_next = sidx_w[IW:0];
                        end
                        REQ_FLUSH:
                        begin
                            fill_next = '0;
                            victim_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_RD: ;
            S_CHK:
            begin
                priority if (op_reg == REQ_PACKET)
                begin
                    if (hit)
                    begin
                        r = apply_pkt(ram_rdata, tx_reg, mac_reg, len_reg, now_reg);
                        ram_we = 1'b1;
                        ram_wdata = r;
                        res_next = report(r, r.live, slot8(idx_reg[IW-1:0]),
                                          tx_reg ? ST_TX : ST_RX, 1'b0);
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else if (op_reg == REQ_READ)
                begin
                    if (view_reg)
                    begin
                        c.txp = ram_rdata.snap_now.txp - ram_rdata.snap_before.txp;
                        c.txb = ram_rdata.snap_now.txb - ram_rdata.snap_before.txb;
                        c.rxp = ram_rdata.snap_now.rxp - ram_rdata.snap_before.rxp;
                        c.rxb = ram_rdata.snap_now.rxb - ram_rdata.snap_before.rxb;
                    end
                    res_next = report(ram_rdata, c, res_reg.slot, ST_READ, 1'b0);
                end
                else
                begin
                    // age or roll one row, then advance
                    if (op_reg == REQ_TICK)
                    begin
                        d = now_reg - ram_rdata.last_seen - {16'd0, cfg.offline_timeout};
                        if (!ram_rdata.idle && d != 32'd0 && !d[31])
                            r.idle = 1'b1;
                        if (last)
                            now_next = now_reg + 32'd1;
                    end
                    else
                    begin
                        r.snap_before = ram_rdata.snap_now;
                        r.snap_now = ram_rdata.live;
                    end
                    ram_we = 1'b1;
                    ram_wdata = r;
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_ALLOC:
            begin
                r = apply_pkt(new_row, tx_reg, mac_reg, len_reg, now_reg);
                ram_addr = alloc_slot;
                ram_we = 1'b1;
                ram_wdata = r;
                res_next = report(r, r.live, slot8(alloc_slot), tx_reg ? ST_TX : ST_RX, 1'b1);
                if (full)
                    victim_next = (victim_reg == LAST_SLOT) ? '0 : victim_reg + 1'b1;
                else
                    fill_next = fill_reg + 1'b1;
            end
            S_RES:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_next = res_reg;
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg <= '0;
            victim_reg <= '0;
            now_reg <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg <= fill_next;
            victim_reg <= victim_next;
            now_reg <= now_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        tx_reg <= tx_next;
        addr_reg <= addr_next;
        mac_reg <= mac_next;
        len_reg <= len_next;
        view_reg <= view_next;
        idx_reg <= idx_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.status = out_reg.status;
    assign out_ch.slot = out_reg.slot;
    assign out_ch.entry_valid = out_reg.entry_valid;
    assign out_ch.new_entry = out_reg.new_entry;
    assign out_ch.host_ip = out_reg.host_ip;
    assign out_ch.host_mac = out_reg.host_mac;
    assign out_ch.offline = out_reg.offline;
    assign out_ch.tx_packets = out_reg.counts.txp;
    assign out_ch.tx_bytes = out_reg.counts.txb;
    assign out_ch.rx_packets = out_reg.counts.rxp;
    assign out_ch.rx_bytes = out_reg.counts.rxb;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= FULL)
        else $error("fill count beyond table size");
    a_victim_full: assert property (@(posedge clk) disable iff (!rst_n)
        (victim_reg != '0) |-> (fill_reg == FULL))
        else $error("victim pointer moved before table filled");
    a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_CHK || state_reg == S_ALLOC))
        else $error("memory write outside update states");
    a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> (state_reg != S_IDLE))
        else $error("accepted item left no work");
`endif
endmodule
`default_nettype wire
